>>> design/spsc_pkg.sv
// spsc_pkg: shared types, command codes and the size-class function for the
// per-slot size class statistics block. No dependencies.
package spsc_pkg;

  // Command codes carried in the request
  typedef enum logic [1:0] {
    CMD_NOTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  localparam int DEFAULT_MAX_SLOTS = 16;
  localparam int NUM_CLASSES       = 8;
  localparam int NUM_LIMITS        = NUM_CLASSES - 1;
  localparam int CLASS_W           = $clog2(NUM_CLASSES);
  localparam int CNT_W             = 64;
  localparam int LEN_SUM_W         = 33;
  localparam int IN_USE_W          = 5;
  // Bin upper limits are CLASS_BASE << (CLASS_STEP * c)
  localparam logic [31:0] CLASS_BASE = 32'd64;
  localparam int CLASS_STEP          = 2;

  localparam logic [0:0] STATUS_OK      = 1'b0;
  localparam logic [0:0] STATUS_NO_SLOT = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  collection;
    logic [15:0] key_length;
    logic [31:0] value_length;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [63:0] total_bytes;
    logic [63:0] record_count;
    logic [63:0] hist_le_64;
    logic [63:0] hist_le_256;
    logic [63:0] hist_le_1k;
    logic [63:0] hist_le_4k;
    logic [63:0] hist_le_16k;
    logic [63:0] hist_le_64k;
    logic [63:0] hist_le_256k;
    logic [63:0] hist_over_256k;
  } result_t;

  // One slot's figures, stored as one memory row
  typedef struct packed {
    logic [CNT_W-1:0]                  total_bytes;
    logic [CNT_W-1:0]                  record_count;
    logic [NUM_CLASSES-1:0][CNT_W-1:0] hist;
  } row_t;

  // Size class: number of bin limits the value exceeds (independent compares)
  function automatic logic [CLASS_W-1:0] size_class(input logic [31:0] v);
    logic [CLASS_W-1:0] c;
    c = '0;
    for (int k = 0; k < NUM_LIMITS; k++) begin
      if (v > (CLASS_BASE << (CLASS_STEP * k))) begin
        c = c + CLASS_W'(1);
      end
    end
    return c;
  endfunction

endpackage

>>> design/per_slot_size_class_stats.sv
// Channel   | Ports                         | Handshake
// ----------+-------------------------------+------------------------------------
// request   | start, busy, request          | taken at edge with start && !busy
// result    | done, result                  | one cycle, marked by done, no stall
// config    | cfg_we, cfg_wdata             | written at edge with cfg_we
//
// For each request, the slot's row is read from the statistics
// memory at the accepting edge, then modified and written back (note) or
// returned (read) in the next cycle; busy is high during that cycle.
// A read's result is marked by done in the cycle right after busy.
// Reset clears the row valid bits at once, so no clearing pass is needed;
// a clear request does the same in its busy cycle.
// The receiver cannot stall; results are never held.
//
// Top level of the per-slot size class statistics block. Uses spsc_pkg,
// spsc_stat_mem and spsc_update.
module per_slot_size_class_stats #(
  parameter int MAX_SLOTS = spsc_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  spsc_pkg::request_t              request,
  output logic                            done,
  output spsc_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [spsc_pkg::IN_USE_W-1:0]   cfg_wdata
);
  import spsc_pkg::*;

  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [IN_USE_W-1:0]  collections_in_use;
  logic                 pending;
  logic [1:0]           cmd_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 in_use_q;
  logic [LEN_SUM_W-1:0] len_sum_q;
  logic [CLASS_W-1:0]   cls_q;
  logic                 accept;
  logic                 in_use_now;
  row_t                 rd_row;
  row_t                 new_row;
  logic                 wr_en;
  logic                 clr;
  result_t              result_next;

  assign accept = start && !busy;
  assign busy   = pending;

  // Slot is live when below both the register and the store depth
  assign in_use_now = ({1'b0, request.collection} < collections_in_use) &&
                      (32'(request.collection) < MAX_SLOTS);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      collections_in_use <= '0;
    end else if (cfg_we) begin
      collections_in_use <= cfg_wdata;
    end
  end

  // Request capture; length sum and size class prepared ahead of the update
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= accept;
    end
    if (accept) begin
      cmd_q     <= request.command;
      addr_q    <= ADDR_W'(request.collection);
      in_use_q  <= in_use_now;
      len_sum_q <= LEN_SUM_W'(request.key_length) + LEN_SUM_W'(request.value_length);
      cls_q     <= size_class(request.value_length);
    end
  end

  spsc_stat_mem #(
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_use_now),
    .rd_addr (ADDR_W'(request.collection)),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (addr_q),
    .wr_row  (new_row),
    .clr     (clr)
  );

  spsc_update u_update (
    .old_row (rd_row),
    .len_sum (len_sum_q),
    .cls     (cls_q),
    .new_row (new_row)
  );

  assign wr_en = pending && (cmd_q == CMD_NOTE) && in_use_q;
  assign clr   = pending && (cmd_q == CMD_CLEAR);

  // Read result, zeros with error status for a slot not in use
  always_comb begin
    result_next = '0;
    if (in_use_q) begin
      result_next.status         = STATUS_OK;
      result_next.total_bytes    = rd_row.total_bytes;
      result_next.record_count   = rd_row.record_count;
      result_next.hist_le_64     = rd_row.hist[0];
      result_next.hist_le_256    = rd_row.hist[1];
      result_next.hist_le_1k     = rd_row.hist[2];
      result_next.hist_le_4k     = rd_row.hist[3];
      result_next.hist_le_16k    = rd_row.hist[4];
      result_next.hist_le_64k    = rd_row.hist[5];
      result_next.hist_le_256k   = rd_row.hist[6];
      result_next.hist_over_256k = rd_row.hist[7];
    end else begin
      result_next.status = STATUS_NO_SLOT;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pending && (cmd_q == CMD_READ);
    end
    if (pending && (cmd_q == CMD_READ)) begin
      result <= result_next;
    end
  end

  // Checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_READ) |-> ##2 done)
    else $error("read request produced no result");

  a_error_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_NO_SLOT) |->
      (result.total_bytes == '0 && result.record_count == '0 &&
       result.hist_over_256k == '0))
    else $error("error result carries nonzero figures");

endmodule

>>> design/spsc_stat_mem.sv
// spsc_stat_mem: slot statistics memory, one row per slot, registered read,
// per-row valid bits so reset and clear take effect at once. Uses spsc_pkg.
module spsc_stat_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output spsc_pkg::row_t     rd_row,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  spsc_pkg::row_t     wr_row,
  input  logic               clr
);
  import spsc_pkg::*;

  row_t             mem [DEPTH];
  logic [DEPTH-1:0] valid;
  row_t             data_q;
  logic             valid_q;

  // Row storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  // Valid bits: a row not written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (clr) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
      end
    end
  end

  assign rd_row = valid_q ? data_q : '0;

endmodule

>>> design/spsc_update.sv
// spsc_update: modify step of the read-modify-write, adds the record's bytes,
// counts the record and bumps its size bin. Uses spsc_pkg.
module spsc_update (
  input  spsc_pkg::row_t                     old_row,
  input  logic [spsc_pkg::LEN_SUM_W-1:0]     len_sum,
  input  logic [spsc_pkg::CLASS_W-1:0]       cls,
  output spsc_pkg::row_t                     new_row
);
  import spsc_pkg::*;

  always_comb begin
    new_row.total_bytes  = old_row.total_bytes + CNT_W'(len_sum);
    new_row.record_count = old_row.record_count + CNT_W'(1);
    // one bin per lane, only the matching one counts up
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls == CLASS_W'(c)) begin
        new_row.hist[c] = old_row.hist[c] + CNT_W'(1);
      end else begin
        new_row.hist[c] = old_row.hist[c];
      end
    end
  end

endmodule
